[rtl/core/dbve_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dbve_pkg
// Shared types, constants and bit-search helpers of the bit vector engine.
// ----------------------------------------------------------------------------
package dbve_pkg;

    localparam int WORD_BITS = 64;
    localparam logic [63:0] TOP_BIT  = 64'h8000000000000000;
    localparam logic [63:0] ALL_ONES = 64'hFFFFFFFFFFFFFFFF;

    typedef enum logic [2:0] {
        A_READ  = 3'd0,
        A_SET   = 3'd1,
        A_CLEAR = 3'd2,
        A_INSERT = 3'd3,
        A_NEXT  = 3'd4,
        A_PREV  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic process;
        logic rd_next;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic no_mem;
        logic walk_end;
        logic out_free;
    } t_stat;

    // offset of the first set bit, offset 0 being the most significant bit
    function automatic logic [5:0] first_set(input logic [63:0] x);
        logic [7:0] nz;
        logic [2:0] sub [8];
        logic [5:0] res;
        logic [7:0] by;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            by = x[63-8*b -: 8];
            nz[b] = |by;
            sub[b] = '0;
            for (int k = 7; k >= 0; k--) begin
                if (by[7-k]) sub[b] = 3'(k);
            end
        end
        for (int b = 7; b >= 0; b--) begin
            if (nz[b]) res = {3'(b), sub[b]};
        end
        return res;
    endfunction

    // offset of the last set bit
    function automatic logic [5:0] last_set(input logic [63:0] x);
        logic [7:0] nz;
        logic [2:0] sub [8];
        logic [5:0] res;
        logic [7:0] by;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            by = x[63-8*b -: 8];
            nz[b] = |by;
            sub[b] = '0;
            for (int k = 0; k < 8; k++) begin
                if (by[7-k]) sub[b] = 3'(k);
            end
        end
        for (int b = 0; b < 8; b++) begin
            if (nz[b]) res = {3'(b), sub[b]};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/core/dbve_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dbve_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dbve_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/core/dbve_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dbve_ctrl
// Sequencer: accept, decode, word walk and result hand-off.
// ----------------------------------------------------------------------------
module dbve_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire dbve_pkg::t_stat i_stat,
    output dbve_pkg::t_cmd      o_cmd
);

    dbve_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbve_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != dbve_pkg::S_IDLE);
        unique case (r_state)
            dbve_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = dbve_pkg::S_DECODE;
                end
            end
            dbve_pkg::S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_state = i_stat.no_mem ? dbve_pkg::S_FINISH : dbve_pkg::S_SCAN;
            end
            dbve_pkg::S_SCAN: begin
                o_cmd.process = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = dbve_pkg::S_FINISH;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            dbve_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = dbve_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/dbve_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dbve_datapath
// Transaction registers, word update and search logic, store, result register.
// ----------------------------------------------------------------------------
module dbve_datapath #(
    parameter int CAPACITY_BITS = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dbve_pkg::t_cmd  i_cmd,
    output dbve_pkg::t_stat      o_stat,
    input  wire logic [2:0]      i_action,
    input  wire logic [12:0]     i_position,
    input  wire logic            i_new_bit,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_bit_value,
    output logic [12:0]          o_distance,
    output logic [12:0]          o_length_now,
    output logic [1:0]           o_status
);

    localparam int NUM_WORDS = (CAPACITY_BITS + dbve_pkg::WORD_BITS - 1) / dbve_pkg::WORD_BITS;
    localparam int AW = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int LEN_W = $clog2(CAPACITY_BITS + 1);
    localparam int PW = (LEN_W > 13 ? LEN_W : 13) + 1;

    dbve_pkg::t_action r_act;
    dbve_pkg::t_status r_status;
    logic [12:0]    r_pos;
    logic           r_nb;
    logic [LEN_W-1:0] r_len;
    logic [AW-1:0]  r_w, r_last;
    logic           r_first, r_carry, r_bit;
    logic [12:0]    r_dist;
    logic           r_o_valid, r_o_bit;
    logic [12:0]    r_o_dist, r_o_len;
    dbve_pkg::t_status r_o_status;

    logic [PW-1:0]  p, l, pm1, lm1, used, w_ext, j;
    logic [5:0]     o, q, off;
    logic [AW-1:0]  start_w, last_w, next_w;
    logic           err, no_mem, hit, we, re;
    dbve_pkg::t_status s_status;
    logic [12:0]    s_dist;
    logic [63:0]    rdata, word, masked, wdata, keep, bitm;

    assign p     = {{(PW-13){1'b0}}, r_pos};
    assign l     = {{(PW-LEN_W){1'b0}}, r_len};
    assign pm1   = p - PW'(1);
    assign lm1   = l - PW'(1);
    assign used  = (l + PW'(63)) >> 6;
    assign w_ext = {{(PW-AW){1'b0}}, r_w};
    assign o     = r_pos[5:0];
    assign q     = pm1[5:0];
    assign next_w = (r_act == dbve_pkg::A_PREV) ? r_w - AW'(1) : r_w + AW'(1);

    always_comb begin
        err      = 1'b0;
        no_mem   = 1'b0;
        s_status = dbve_pkg::ST_DONE;
        s_dist   = '0;
        start_w  = p[AW+5:6];
        last_w   = p[AW+5:6];
        unique case (r_act)
            dbve_pkg::A_READ, dbve_pkg::A_SET, dbve_pkg::A_CLEAR: begin
                err = (p >= l);
            end
            dbve_pkg::A_INSERT: begin
                err    = (p > l);
                last_w = l[AW+5:6];
                if (!err && l >= PW'(CAPACITY_BITS)) begin
                    no_mem   = 1'b1;
                    s_status = dbve_pkg::ST_FULL;
                end
            end
            dbve_pkg::A_NEXT: begin
                err    = (p >= l);
                last_w = lm1[AW+5:6];
                s_dist = 13'(l - p);
            end
            dbve_pkg::A_PREV: begin
                err     = (p > l);
                start_w = pm1[AW+5:6];
                last_w  = '0;
                if (r_pos == 13'd0) no_mem = 1'b1;
                else s_dist = 13'(p + PW'(1));
            end
            default: no_mem = 1'b1;
        endcase
        if (err) begin
            no_mem   = 1'b1;
            s_status = dbve_pkg::ST_RANGE;
            s_dist   = '0;
        end
    end

    assign word = (w_ext < used) ? rdata : '0;
    assign keep = ~(dbve_pkg::ALL_ONES >> o);
    assign bitm = dbve_pkg::TOP_BIT >> o;

    always_comb begin
        masked = word;
        wdata  = word;
        we     = 1'b0;
        hit    = 1'b0;
        off    = '0;
        j      = '0;
        unique case (r_act)
            dbve_pkg::A_SET: begin
                wdata = word | bitm;
                we    = i_cmd.process;
            end
            dbve_pkg::A_CLEAR: begin
                wdata = word & ~bitm;
                we    = i_cmd.process;
            end
            dbve_pkg::A_INSERT: begin
                if (r_first) begin
                    wdata = (word & keep) | (r_nb ? bitm : 64'd0) | ((word >> 1) & ~keep & ~bitm);
                end else begin
                    wdata = {r_carry, word[63:1]};
                end
                we = i_cmd.process;
            end
            dbve_pkg::A_NEXT: begin
                if (r_first) masked = word & ((dbve_pkg::ALL_ONES >> o) >> 1);
                hit = |masked;
                off = dbve_pkg::first_set(masked);
            end
            dbve_pkg::A_PREV: begin
                if (r_first) masked = word & ~((dbve_pkg::ALL_ONES >> q) >> 1);
                hit = |masked;
                off = dbve_pkg::last_set(masked);
            end
            default: ;
        endcase
        j = {{(PW-AW-6){1'b0}}, r_w, off};
    end

    assign re = (i_cmd.setup && !no_mem) || i_cmd.rd_next;

    dbve_ram #(
        .WIDTH(dbve_pkg::WORD_BITS),
        .DEPTH(NUM_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_w),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(i_cmd.setup ? start_w : next_w),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= dbve_pkg::t_action'(i_action);
            r_pos <= i_position;
            r_nb  <= i_new_bit;
        end
        if (i_cmd.setup) begin
            r_w      <= start_w;
            r_last   <= last_w;
            r_first  <= 1'b1;
            r_status <= s_status;
            r_dist   <= s_dist;
            r_bit    <= 1'b0;
        end
        if (i_cmd.process) begin
            r_first <= 1'b0;
            r_carry <= word[0];
            if (r_act == dbve_pkg::A_READ) r_bit <= word[~o];
            if (hit && r_act == dbve_pkg::A_NEXT) r_dist <= 13'(j - p);
            if (hit && r_act == dbve_pkg::A_PREV) r_dist <= 13'(p - j);
            if (!o_stat.walk_end) r_w <= next_w;
        end
        if (i_cmd.push) begin
            r_o_bit    <= r_bit;
            r_o_dist   <= r_dist;
            r_o_len    <= l[12:0];
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.process && o_stat.walk_end && r_act == dbve_pkg::A_INSERT) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_cmd.push) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    assign o_stat.no_mem   = no_mem;
    assign o_stat.walk_end = hit || (r_w == r_last);
    assign o_stat.out_free = !r_o_valid || !i_stall;

    assign o_valid      = r_o_valid;
    assign o_bit_value  = r_o_bit;
    assign o_distance   = r_o_dist;
    assign o_length_now = r_o_len;
    assign o_status     = r_o_status;

endmodule
`default_nettype wire

[rtl/core/dynamic_bitvector_engine_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dynamic_bitvector_engine_core
// Growable bit vector with read, set, clear, insert and set-bit searches.
// ----------------------------------------------------------------------------
// One transaction at a time: accept, decode, word walk, result hand-off.
// Rejected requests, prev search at position zero and unused action codes
// skip the walk. Read, set and clear walk the single word of the position.
// Insert and the searches walk the 64-bit words in turn (insert: from the
// word of the position up to the word of the length; searches: until the
// first word holding a set bit or the end), one word a cycle through the
// single read port of the word store.
// No clearing pass: words beyond the current length read as zero.
module dynamic_bitvector_engine_core #(
    parameter int CAPACITY_BITS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_action,
    input  wire logic [12:0] i_position,
    input  wire logic        i_new_bit,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_bit_value,
    output logic [12:0]      o_distance,
    output logic [12:0]      o_length_now,
    output logic [1:0]       o_status
);

    dbve_pkg::t_cmd  cmd;
    dbve_pkg::t_stat stat;

    dbve_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    dbve_datapath #(
        .CAPACITY_BITS(CAPACITY_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_new_bit   (i_new_bit),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bit_value (o_bit_value),
        .o_distance  (o_distance),
        .o_length_now(o_length_now),
        .o_status    (o_status)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a transaction is in flight");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dbve_pkg::ST_FULL) |-> (o_length_now == 13'(CAPACITY_BITS)))
        else $error("full status without full length");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != dbve_pkg::ST_DONE) |-> (!o_bit_value && o_distance == 13'd0))
        else $error("rejected transaction carries data");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.setup, cmd.process, cmd.push}))
        else $error("overlapping sequencer commands");

endmodule
`default_nettype wire

[tb/dynamic_bitvector_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// dynamic_bitvector_engine_core_tb
// Drives read, set, clear, insert and set-bit search transactions into the
// bit vector engine. A behavioural copy of the vector predicts each result,
// and the monitor compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module dynamic_bitvector_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 4096;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [2:0]  action;
        logic [12:0] position;
        logic        new_bit;
    } t_req;

    typedef struct packed {
        logic        bit_value;
        logic [12:0] distance;
        logic [12:0] length_now;
        logic [1:0]  status;
    } t_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [12:0] i_position;
    logic        i_new_bit;
    logic        o_valid;
    logic        i_stall;
    logic        o_bit_value;
    logic [12:0] o_distance;
    logic [12:0] o_length_now;
    logic [1:0]  o_status;

    dynamic_bitvector_engine_core #(.CAPACITY_BITS(CAP)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_position(i_position), .i_new_bit(i_new_bit),
        .o_valid(o_valid), .i_stall(i_stall), .o_bit_value(o_bit_value),
        .o_distance(o_distance), .o_length_now(o_length_now), .o_status(o_status)
    );

    t_req        pending_reqs[$];
    t_rsp        expected_rsps[$];
    logic        vec_bits[CAP];
    int          vec_len;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          error_count;
    int          cycle_count;
    int          accepted_count;
    int          queued_count;
    logic        hold_sender;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_rsp predict_vector(input t_req r);
        t_rsp p;
        int   pos;
        pos = int'(r.position);
        p = '0;
        case (r.action)
            dbve_pkg::A_READ: begin
                if (pos < vec_len) p.bit_value = vec_bits[pos];
                else p.status = dbve_pkg::ST_RANGE;
            end
            dbve_pkg::A_SET, dbve_pkg::A_CLEAR: begin
                if (pos < vec_len) vec_bits[pos] = (r.action == dbve_pkg::A_SET);
                else p.status = dbve_pkg::ST_RANGE;
            end
            dbve_pkg::A_INSERT: begin
                if (pos > vec_len) p.status = dbve_pkg::ST_RANGE;
                else if (vec_len >= CAP) p.status = dbve_pkg::ST_FULL;
                else begin
                    for (int i = vec_len; i > pos; i--) vec_bits[i] = vec_bits[i-1];
                    vec_bits[pos] = r.new_bit;
                    vec_len++;
                end
            end
            dbve_pkg::A_NEXT: begin
                if (pos >= vec_len) p.status = dbve_pkg::ST_RANGE;
                else begin
                    p.distance = 13'(vec_len - pos);
                    for (int i = pos + 1; i < vec_len; i++) begin
                        if (vec_bits[i]) begin
                            p.distance = 13'(i - pos);
                            break;
                        end
                    end
                end
            end
            dbve_pkg::A_PREV: begin
                if (pos > vec_len) p.status = dbve_pkg::ST_RANGE;
                else if (pos != 0) begin
                    p.distance = 13'(pos + 1);
                    for (int i = pos; i > 0; i--) begin
                        if (vec_bits[i-1]) begin
                            p.distance = 13'(pos - (i - 1));
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        p.length_now = 13'(vec_len);
        return p;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) accepted_count++;
            if (pending_reqs.size() != 0 && !hold_sender &&
                    $urandom_range(99) >= sender_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_valid    <= 1'b1;
                i_action   <= r.action;
                i_position <= r.position;
                i_new_bit  <= r.new_bit;
                expected_rsps.push_back(predict_vector(r));
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected transaction");
                error_count++;
            end else begin
                t_rsp e;
                e = expected_rsps.pop_front();
                if (o_bit_value !== e.bit_value) begin
                    $error("bit_value exp %0d got %0d", e.bit_value, o_bit_value);
                    error_count++;
                end
                if (o_distance !== e.distance) begin
                    $error("distance exp %0d got %0d", e.distance, o_distance);
                    error_count++;
                end
                if (o_length_now !== e.length_now) begin
                    $error("length_now exp %0d got %0d", e.length_now, o_length_now);
                    error_count++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dynamic_bitvector_engine_core_tb: errors");
            $finish;
        end
    end

    function automatic void add_req(input int a, input int p, input int b);
        t_req r;
        r.action = 3'(a);
        r.position = 13'(p);
        r.new_bit = 1'(b);
        pending_reqs.push_back(r);
        queued_count++;
    endfunction

    // bias positions towards the live part of the vector and its edges
    function automatic int pick_position(input int len);
        int k;
        k = $urandom_range(19);
        if (k == 0) return $urandom_range(8191);
        if (k == 1) return len;
        if (k == 2) return len + 1;
        if (k == 3) return 0;
        if (len == 0) return 0;
        return $urandom_range(len - 1);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || expected_rsps.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int sim_len;
        int a;
        int p;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = '0;
        i_position = '0;
        i_new_bit = 1'b0;
        hold_sender = 1'b0;
        error_count = 0;
        cycle_count = 0;
        accepted_count = 0;
        queued_count = 0;
        vec_len = 0;
        foreach (vec_bits[i]) vec_bits[i] = 1'b0;
        sender_idle_pct = 16;
        receiver_idle_pct = 71;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_req(dbve_pkg::A_READ, 0, 0);
        add_req(dbve_pkg::A_NEXT, 0, 0);
        add_req(dbve_pkg::A_PREV, 0, 0);
        add_req(dbve_pkg::A_PREV, 1, 0);
        add_req(dbve_pkg::A_INSERT, 1, 1);
        add_req(dbve_pkg::A_INSERT, 0, 1);
        add_req(dbve_pkg::A_INSERT, 1, 0);
        add_req(dbve_pkg::A_INSERT, 0, 0);
        add_req(dbve_pkg::A_READ, 1, 0);
        add_req(dbve_pkg::A_NEXT, 0, 0);
        add_req(dbve_pkg::A_NEXT, 2, 0);
        add_req(dbve_pkg::A_PREV, 3, 0);
        add_req(dbve_pkg::A_PREV, 0, 0);
        add_req(dbve_pkg::A_CLEAR, 1, 0);
        add_req(dbve_pkg::A_PREV, 3, 0);
        add_req(dbve_pkg::A_SET, 2, 0);
        add_req(dbve_pkg::A_SET, 8191, 1);
        add_req(dbve_pkg::A_CLEAR, 3, 0);
        add_req(6, 0, 1);
        add_req(7, 8191, 1);
        add_req(dbve_pkg::A_PREV, 3, 0);
        sim_len = 3;

        hold_sender = 1'b0;
        wait_drained();
        hold_sender = 1'b1;
        @(negedge i_clk);
        hold_sender = 1'b0;

        // three phases; the last ends with requests around the length
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                sender_idle_pct = 71;
                receiver_idle_pct = 16;
            end else if (ph == 2) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            for (int n = 0; n < 380; n++) begin
                a = $urandom_range(99);
                if (a < 40) a = dbve_pkg::A_INSERT;
                else if (a < 50) a = dbve_pkg::A_READ;
                else if (a < 60) a = dbve_pkg::A_SET;
                else if (a < 66) a = dbve_pkg::A_CLEAR;
                else if (a < 80) a = dbve_pkg::A_NEXT;
                else if (a < 96) a = dbve_pkg::A_PREV;
                else a = $urandom_range(7);
                p = pick_position(sim_len);
                if (a == dbve_pkg::A_INSERT && p <= sim_len && sim_len < CAP) sim_len++;
                add_req(a, p, $urandom_range(1));
            end
            if (ph == 2) begin
                add_req(dbve_pkg::A_INSERT, sim_len, 1);
                if (sim_len < CAP) sim_len++;
                add_req(dbve_pkg::A_INSERT, sim_len + 1, 0);
                add_req(dbve_pkg::A_READ, sim_len - 1, 0);
                add_req(dbve_pkg::A_NEXT, sim_len - 1, 0);
                add_req(dbve_pkg::A_PREV, sim_len, 0);
                add_req(dbve_pkg::A_NEXT, 0, 0);
                add_req(dbve_pkg::A_READ, sim_len, 0);
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("dynamic_bitvector_engine_core_tb: clean");
        end else begin
            $display("dynamic_bitvector_engine_core_tb: errors");
        end
        $finish;
    end

endmodule
